FILE: rtl/dwsc_pkg.sv
// Package with shared types and command codes of the word segmentation checker.
`default_nettype none
package dwsc_pkg;
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_DICT  = 2'd1,
		CMD_TEXT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic segmentable;
		logic words_dropped;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/dwsc_in_if.sv
// Valid/ready channel interface carrying one input item.
`default_nettype none
interface dwsc_in_if;
	logic              valid;
	logic              ready;
	dwsc_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/dwsc_out_if.sv
// Valid/ready channel interface carrying one result item.
`default_nettype none
interface dwsc_out_if;
	logic               valid;
	logic               ready;
	dwsc_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/dwsc_cell.sv
// One comparison cell: holds one text window character and compares it with a stored letter.
`default_nettype none
module dwsc_cell (
	input  wire logic       clk,
	input  wire logic       shift,
	input  wire logic [7:0] ch_in,
	input  wire logic [7:0] dict_ch,
	output logic [7:0]      ch_q,
	output logic            eq
);
	always_ff @(posedge clk) begin
		if (shift) begin
			ch_q <= ch_in;
		end
	end
	assign eq = (ch_q == dict_ch);
endmodule
`default_nettype wire

FILE: rtl/dictionary_word_segmentation_check_unit.sv
// Top level of the dictionary word segmentation checker.
//
// Usage: one input channel (in_ch) carries commands: clear dictionary,
// dictionary character (last marks word end) and text character (last marks
// text end). One output channel (out_ch) carries a result only for the final
// text character: segmentable and words_dropped.
// Dictionary characters and clears are taken one per cycle while the block
// is idle. A text character shifts into a chain of comparison cells holding
// the last MAX_WORD_LEN text characters, then the stored words are read and
// compared one per cycle. The scan stops early on the first matching word and
// is followed by a closing state, and no item is taken during either; the
// single read port of the word memory sets the scan's length. The result sits
// in an output register; no further item is taken until it is transferred, so
// a stalled receiver holds the block.
// After reset the dictionary is empty and only the start position is
// reachable. No clearing pass is needed: only rows below the word count are
// ever read, and window cells older than the start of the text never count.
`default_nettype none
module dictionary_word_segmentation_check_unit #(
	parameter int MAX_WORDS    = 64,
	parameter int MAX_WORD_LEN = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dwsc_in_if.sink   in_ch,
	dwsc_out_if.source out_ch
);
	import dwsc_pkg::*;

	localparam int LW = $clog2(MAX_WORD_LEN + 1);
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

	// Dictionary memory: one row per word, row holds every character.
	logic [MAX_WORD_LEN*8-1:0] row_mem [MAX_WORDS];
	logic [LW-1:0]             len_mem [MAX_WORDS];
	logic [MAX_WORD_LEN*8-1:0] row_rd_q;
	logic [LW-1:0]             len_rd_q;

	logic [MAX_WORD_LEN*8-1:0] part_row_q;
	logic [MAX_WORD_LEN*8-1:0] new_row;
	logic [CW-1:0]             word_count_q;
	logic [LW-1:0]             part_len_q;
	logic                      part_long_q;
	logic                      ovf_q;
	logic [MAX_WORD_LEN:0]     reach_q;
	logic                      fin_q;

	state_t        state_q, state_d;
	logic [CW-1:0] scan_q;
	logic          rd_valid_q;
	logic          out_valid_q;
	out_item_t     out_q;

	in_item_t it;
	logic     acc, shift, hit, scan_end;
	logic [7:0] win [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] eq, ok;

	assign it    = in_ch.payload;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign acc   = in_ch.valid && in_ch.ready;
	assign shift = acc && (cmd_t'(it.cmd) == CMD_TEXT);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

	// Chain of cells: cell 0 takes the new character, each hands on to the next.
	for (genvar j = 0; j < MAX_WORD_LEN; j++) begin : g_cell
		logic [7:0] dch;
		logic [PW-1:0] sel;
		logic [7:0] prev;
		if (j == 0) begin : g_first
			assign prev = it.ch;
		end else begin : g_next
			assign prev = win[j-1];
		end
		// Window entry j is compared with word letter len-1-j.
		assign sel = PW'(len_rd_q - LW'(1) - LW'(j));
		assign dch = row_rd_q[sel*8 +: 8];
		dwsc_cell u_cell (
			.clk(clk), .shift(shift), .ch_in(prev), .dict_ch(dch),
			.ch_q(win[j]), .eq(eq[j])
		);
		assign ok[j] = eq[j] || (LW'(j) >= len_rd_q);
	end

	// Window cells carry no reset: a word is only tried where its start is a
	// reachable position, so cells older than the start of the text never
	// decide a match.
	assign hit = rd_valid_q && (len_rd_q != '0) && reach_q[len_rd_q - LW'(1)] && (&ok);
	assign scan_end = (scan_q >= word_count_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (shift) state_d = ST_SCAN;
			ST_SCAN: if (hit || (scan_end && !rd_valid_q)) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Row as it will be stored: the partial word plus its final character.
	always_comb begin
		new_row = part_row_q;
		if (part_len_q < LW'(MAX_WORD_LEN)) begin
			new_row[part_len_q[PW-1:0]*8 +: 8] = it.ch;
		end
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (acc && cmd_t'(it.cmd) == CMD_DICT && it.last && !part_long_q
				&& part_len_q < LW'(MAX_WORD_LEN)
				&& word_count_q < CW'(MAX_WORDS)) begin
			row_mem[word_count_q[AW-1:0]] <= new_row;
			len_mem[word_count_q[AW-1:0]] <= LW'(part_len_q + LW'(1));
		end
		if (state_q == ST_SCAN && !scan_end) begin
			row_rd_q <= row_mem[scan_q[AW-1:0]];
			len_rd_q <= len_mem[scan_q[AW-1:0]];
		end
		if (acc && cmd_t'(it.cmd) == CMD_DICT && part_len_q < LW'(MAX_WORD_LEN)) begin
			part_row_q[part_len_q[PW-1:0]*8 +: 8] <= it.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			part_len_q   <= '0;
			part_long_q  <= 1'b0;
			ovf_q        <= 1'b0;
			reach_q      <= (MAX_WORD_LEN+1)'(1);
			fin_q        <= 1'b0;
			scan_q       <= '0;
			rd_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (acc) begin
				case (cmd_t'(it.cmd))
					CMD_CLEAR: begin
						word_count_q <= '0;
						part_len_q   <= '0;
						part_long_q  <= 1'b0;
						ovf_q        <= 1'b0;
					end
					CMD_DICT: begin
						if (it.last) begin
							if (part_long_q || part_len_q >= LW'(MAX_WORD_LEN)
									|| word_count_q >= CW'(MAX_WORDS)) begin
								ovf_q <= 1'b1;
							end else begin
								word_count_q <= CW'(word_count_q + CW'(1));
							end
							part_len_q  <= '0;
							part_long_q <= 1'b0;
						end else if (part_len_q >= LW'(MAX_WORD_LEN)) begin
							part_long_q <= 1'b1;
						end else begin
							part_len_q <= LW'(part_len_q + LW'(1));
						end
					end
					CMD_TEXT: begin
						fin_q      <= it.last;
						scan_q     <= '0;
						rd_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_SCAN: begin
					rd_valid_q <= !scan_end;
					if (!scan_end) scan_q <= CW'(scan_q + CW'(1));
					if (hit || (scan_end && !rd_valid_q)) begin
						reach_q <= {reach_q[MAX_WORD_LEN-1:0], hit};
						if (fin_q) begin
							out_valid_q <= 1'b1;
							out_q <= '{segmentable: hit, words_dropped: ovf_q};
						end
					end
				end
				ST_DONE: begin
					rd_valid_q <= 1'b0;
					if (fin_q) reach_q <= (MAX_WORD_LEN+1)'(1);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
